// ----- hw/rtl/jsfe_pkg.sv -----
// ----------------------------------------------------------------------------
// jsfe_pkg
// Shared types and constants for the JSON string field extractor.
// ----------------------------------------------------------------------------
package jsfe_pkg;

  localparam int MaxKeyLen  = 16;   // default longest key the window can hold
  localparam int QueueDepth = 2;    // entries between front and back
  localparam int KeyLenW    = 5;    // key_length register width
  localparam int CapW       = 8;    // out_capacity register width
  localparam int CfgW       = 64;   // widest register
  localparam int CfgAddrW   = 2;
  localparam int KeyChars   = 16;   // characters held by the two key registers

  localparam logic [CapW-1:0] CapReset = 8'd16;

  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChLowerN = 8'h6e;
  localparam logic [7:0] ChLowerR = 8'h72;
  localparam logic [7:0] ChLowerT = 8'h74;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNul = 8'h00;

  typedef enum logic [CfgAddrW-1:0] {
    CfgKeyLow  = 2'd0,
    CfgKeyHigh = 2'd1,
    CfgKeyLen  = 2'd2,
    CfgCap     = 2'd3
  } jsfe_cfg_e;

  typedef enum logic [2:0] {
    PhSearch = 3'd0,
    PhColon  = 3'd1,
    PhQuote  = 3'd2,
    PhValue  = 3'd3,
    PhEscape = 3'd4,
    PhDone   = 3'd5
  } jsfe_phase_e;

  // Results of one byte: an optional character, then an optional finish.
  typedef struct packed {
    logic       has_char;
    logic [7:0] char_value;
    logic       has_done;
    logic       found;
    logic [7:0] value_length;
  } jsfe_entry_t;

endpackage

// ----- hw/rtl/jsfe_front.sv -----
// ----------------------------------------------------------------------------
// jsfe_front
// Config registers, key window match and phase machine; one byte per cycle while the queue is not full.
// ----------------------------------------------------------------------------
module jsfe_front import jsfe_pkg::*; #(
  parameter int MAX_KEY_LEN = MaxKeyLen
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_i,
  input  logic                last_i,
  input  logic                full_i,
  output logic                push_o,
  output jsfe_entry_t         entry_o
);

  localparam int WinDepth = MAX_KEY_LEN + 2;
  localparam int FillW    = $clog2(WinDepth + 1);

  logic [CfgW-1:0]    key_lo_q, key_hi_q;
  logic [KeyLenW-1:0] key_len_q;
  logic [CapW-1:0]    cap_q;

  jsfe_phase_e        ph_q, ph_d;
  logic [7:0]         cnt_q, cnt_d;
  logic [FillW-1:0]   fill_q, fill_d, fill_inc;
  logic [7:0]         win_q [WinDepth];
  logic [7:0]         win_sh [WinDepth];
  logic               shift;

  logic [7:0]         key_ch [KeyChars];
  logic [KeyLenW-1:0] klen;
  logic [WinDepth-1:0] pos_ok;
  logic               match;
  logic               fire;
  logic               allow;

  function automatic logic is_space(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChCr) || (b == ChLf);
  endfunction

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      key_len_q <= '0;
      cap_q     <= CapReset;
    end else if (cfg_we_i) begin
      unique case (jsfe_cfg_e'(cfg_addr_i))
        CfgKeyLow:  key_lo_q  <= cfg_wdata_i;
        CfgKeyHigh: key_hi_q  <= cfg_wdata_i;
        CfgKeyLen:  key_len_q <= cfg_wdata_i[KeyLenW-1:0];
        CfgCap:     cap_q     <= cfg_wdata_i[CapW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < KeyChars; i++) begin
      key_ch[i] = (i < 8) ? key_lo_q[8*(i%8) +: 8] : key_hi_q[8*(i%8) +: 8];
    end
  end

  assign klen = (key_len_q > KeyLenW'(MAX_KEY_LEN)) ? KeyLenW'(MAX_KEY_LEN) : key_len_q;

  // window after taking the current byte, newest at entry 0
  always_comb begin
    win_sh[0] = data_i;
    for (int j = 1; j < WinDepth; j++) begin
      win_sh[j] = win_q[j-1];
    end
  end

  assign fill_inc = (fill_q == FillW'(WinDepth)) ? fill_q : fill_q + FillW'(1);

  // per-position compare: quote, key reversed, quote
  always_comb begin
    logic [KeyLenW-1:0] idx;
    logic [7:0]         want;
    for (int j = 0; j < WinDepth; j++) begin
      idx  = klen - KeyLenW'(j);
      want = (idx < KeyLenW'(KeyChars)) ? key_ch[idx[$clog2(KeyChars)-1:0]] : ChNul;
      if (j == 0 || 6'(j) == 6'(klen) + 6'd1) begin
        pos_ok[j] = (win_sh[j] == ChQuote);
      end else if (6'(j) <= 6'(klen)) begin
        pos_ok[j] = (win_sh[j] == want);
      end else begin
        pos_ok[j] = 1'b1;
      end
    end
  end

  assign match = (6'(fill_inc) >= 6'(klen) + 6'd2) && (&pos_ok);

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign allow      = (cap_q != '0) && ({1'b0, cnt_q} + 9'd1 < {1'b0, cap_q});

  always_comb begin
    jsfe_phase_e ph_n;
    logic        want_char;
    logic [7:0]  ch;
    logic        want_done;
    logic        ok;
    ph_n      = ph_q;
    want_char = 1'b0;
    ch        = ChNul;
    want_done = 1'b0;
    ok        = 1'b0;
    shift     = 1'b0;
    unique case (ph_q)
      PhSearch: begin
        if (data_i == ChNul) begin
          want_done = 1'b1;
        end else begin
          shift = 1'b1;
          if (match) ph_n = PhColon;
        end
      end
      PhColon: begin
        if (data_i == ChColon) ph_n = PhQuote;
        else if (!is_space(data_i)) want_done = 1'b1;
      end
      PhQuote: begin
        if (data_i == ChQuote) ph_n = PhValue;
        else if (!is_space(data_i)) want_done = 1'b1;
      end
      PhValue: begin
        if (data_i == ChNul) begin
          want_done = 1'b1;
        end else if (data_i == ChQuote) begin
          want_done = 1'b1;
          ok        = 1'b1;
        end else if (data_i == ChBslash) begin
          ph_n = PhEscape;
        end else begin
          want_char = 1'b1;
          ch        = data_i;
        end
      end
      PhEscape: begin
        want_char = 1'b1;
        if (data_i == ChNul) begin
          ch        = ChBslash;
          want_done = 1'b1;
        end else begin
          unique case (data_i)
            ChLowerN: ch = ChLf;
            ChLowerR: ch = ChCr;
            ChLowerT: ch = ChTab;
            default:  ch = data_i;
          endcase
          ph_n = PhValue;
        end
      end
      default: ;
    endcase
    if (want_done) ph_n = PhDone;

    // end of message: flush a pending backslash, then close
    if (last_i) begin
      if (ph_n == PhEscape) begin
        want_char = 1'b1;
        ch        = ChBslash;
      end
      if (ph_n != PhDone) want_done = 1'b1;
    end

    entry_o.has_char     = want_char && allow;
    entry_o.char_value   = ch;
    entry_o.has_done     = want_done;
    entry_o.found        = ok && (cap_q != '0);
    entry_o.value_length = cnt_q + 8'(entry_o.has_char);

    ph_d   = ph_q;
    cnt_d  = cnt_q;
    fill_d = fill_q;
    if (fire) begin
      if (last_i) begin
        ph_d   = PhSearch;
        cnt_d  = '0;
        fill_d = '0;
      end else begin
        ph_d   = want_done ? PhDone : ph_n;
        cnt_d  = entry_o.value_length;
        fill_d = shift ? fill_inc : fill_q;
      end
    end
  end

  assign push_o = fire && (entry_o.has_char || entry_o.has_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhSearch;
      cnt_q  <= '0;
      fill_q <= '0;
    end else begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      fill_q <= fill_d;
    end
  end

  // window contents need no reset: the fill count masks stale bytes
  always_ff @(posedge clk_i) begin
    if (fire && shift) win_q <= win_sh;
  end

endmodule

// ----- hw/rtl/jsfe_queue.sv -----
// ----------------------------------------------------------------------------
// jsfe_queue
// Short FIFO of result entries between front and back.
// ----------------------------------------------------------------------------
module jsfe_queue import jsfe_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  jsfe_entry_t entry_i,
  input  logic        pop_i,
  output jsfe_entry_t head_o,
  output logic        empty_o,
  output logic        full_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  jsfe_entry_t     mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i)  rd_q <= ptr_inc(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule

// ----- hw/rtl/jsfe_back.sv -----
// ----------------------------------------------------------------------------
// jsfe_back
// Unpacks a queue entry into one or two output transfers.
// ----------------------------------------------------------------------------
module jsfe_back import jsfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  jsfe_entry_t head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        kind_o,
  output logic [7:0]  char_value_o,
  output logic        found_o,
  output logic [7:0]  value_length_o,
  output logic        last_o
);

  logic char_sent_q;
  logic is_char;
  logic xfer;

  assign is_char = head_i.has_char && !char_sent_q;
  assign valid_o = !empty_i;
  assign last_o  = is_char ? !head_i.has_done : 1'b1;
  assign kind_o  = !is_char;

  assign char_value_o   = is_char ? head_i.char_value : ChNul;
  assign found_o        = is_char ? 1'b0 : head_i.found;
  assign value_length_o = is_char ? 8'd0 : head_i.value_length;

  assign xfer  = valid_o && ready_i;
  assign pop_o = xfer && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_sent_q <= 1'b0;
    end else if (pop_o) begin
      char_sent_q <= 1'b0;
    end else if (xfer) begin
      char_sent_q <= 1'b1;
    end
  end

endmodule

// ----- hw/rtl/json_string_field_extractor.sv -----
// ----------------------------------------------------------------------------
// json_string_field_extractor
// Finds a quoted key in a byte stream and streams out its unescaped string
// value, followed by a finish transfer with found flag and length.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                     Payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata[7:0] data_byte, tlast message_end
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata char/found/length, tuser kind,
//                                             tlast run_last
// cfg      in   cfg_we_i (no wait)            cfg_addr_i index, cfg_wdata_i value
//
// One byte is taken per cycle. Each byte is fully decided in the cycle it is
// accepted; the key compare runs against an 18-entry shift window in that same
// cycle. A byte yielding both a character and the finish takes two output
// transfers; 0/1-result bytes sustain 1 byte/cycle while the output is ready.
// A 2-entry queue sits between front and back; the input stalls only when it
// is full. Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module json_string_field_extractor import jsfe_pkg::*; #(
  parameter int MAX_KEY_LEN = MaxKeyLen
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  // byte stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tlast,   // message_end
  // results out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // [7:0] char_value, [8] found,
                                              // [16:9] value_length, [23:17] zero
  output logic                m_axis_tuser,   // [0] kind: 0 char, 1 finish
  output logic                m_axis_tlast    // run_last
);

  jsfe_entry_t entry, head;
  logic        push, pop, q_empty, q_full;
  logic [7:0]  char_value, value_length;
  logic        found;

  // Front: config, window match, phase machine
  jsfe_front #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .data_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .full_i     (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  // Decoupling queue; only bytes with results take an entry
  jsfe_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // Back: char transfer first, finish transfer second
  jsfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .valid_o       (m_axis_tvalid),
    .ready_i       (m_axis_tready),
    .kind_o        (m_axis_tuser),
    .char_value_o  (char_value),
    .found_o       (found),
    .value_length_o(value_length),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, value_length, found, char_value};

endmodule

// ----- hw/rtl/jsfe_checker.sv -----
// ----------------------------------------------------------------------------
// jsfe_checker
// Port-level checks on the extractor's output stream.
// ----------------------------------------------------------------------------
module jsfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // finish is always the last result of its byte
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("finish transfer without tlast");

  // char transfers carry no found/length
  a_char_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0)
    else $error("char transfer with nonzero finish fields");

  // value length stays below 255 (at most capacity minus one characters)
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[16:9] != 8'd255)
    else $error("value length out of range");

  // stalled output holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

endmodule

bind json_string_field_extractor jsfe_checker u_jsfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
